[hdl/row_fir_mirror_boundary_defines.svh]
// assertion macros for the row fir checker
// included by the checker file; depends on nothing
`ifndef ROW_FIR_MIRROR_BOUNDARY_DEFINES_SVH
`define ROW_FIR_MIRROR_BOUNDARY_DEFINES_SVH

// implication checked while out of reset
`define RFMB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked while out of reset
`define RFMB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication checked at every edge, reset included
`define RFMB_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/rfmb_pkg.sv]
// shared types and constants of the row fir filter
// no dependencies
package rfmb_pkg;

    localparam int MAX_TAPS    = 31;
    localparam int SAMPLE_BITS = 16;
    localparam int TAP_BITS    = 16;
    localparam int FRAC_BITS   = 15;
    localparam int IDX_W       = $clog2(MAX_TAPS);
    localparam int CNT_W       = 5;
    localparam int TAP_IDX_W   = 5;
    localparam int OFF_W       = IDX_W + 2;
    localparam int ROW_W       = 16;
    localparam int PROD_W      = SAMPLE_BITS + TAP_BITS;
    localparam int ACC_W       = PROD_W + IDX_W + 1;
    localparam int GROUPS      = (MAX_TAPS + 7) / 8;
    localparam int S_DATA_BITS = TAP_IDX_W + SAMPLE_BITS;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 5;

    // item kinds
    localparam logic KIND_TAP   = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_TAP_COUNT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIRROR_MODE = 2'd1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [TAP_BITS-1:0]    tap_t;
    typedef sample_t [MAX_TAPS-1:0]        sample_vec_t;
    typedef tap_t [MAX_TAPS-1:0]           tap_vec_t;

    // one output to compute: padded samples per lane plus flags
    typedef struct packed {
        sample_vec_t samples;
        logic        row_done;
        logic        short_row;
    } job_t;

    // back-end occupancy seen by the front
    typedef struct packed {
        logic queue_empty;
        logic back_empty;
    } status_t;

endpackage

[hdl/rfmb_front.sv]
// front end: accepts items, holds taps, sample window and row position,
// and issues one job per output; depends on rfmb_pkg
module rfmb_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rfmb_pkg::S_TDATA_W-1:0]    s_tdata,  // tap_index, sample_value
    input  logic                              s_tuser,  // kind
    input  logic                              s_tlast,
    input  logic [rfmb_pkg::CNT_W-1:0]        tap_count,
    input  logic                              mirror_mode,
    input  rfmb_pkg::status_t                 status,
    output logic                              push,
    input  logic                              push_ready,
    output rfmb_pkg::job_t                    job,
    output rfmb_pkg::tap_vec_t                taps
);

    rfmb_pkg::sample_t                 win_reg [rfmb_pkg::MAX_TAPS];
    rfmb_pkg::tap_vec_t                taps_reg;
    logic [rfmb_pkg::ROW_W-1:0]        rowpos_reg;
    logic                              pend_reg;
    logic [rfmb_pkg::IDX_W-1:0]        jd_reg;
    logic [rfmb_pkg::ROW_W-1:0]        jn_reg;
    logic                              jshort_reg;
    logic                              jlast_reg;

    logic [rfmb_pkg::CNT_W-1:0]        k_eff;
    logic [rfmb_pkg::IDX_W-1:0]        half;
    logic                              final_job;
    logic                              free;
    logic                              is_tap;
    logic                              accept;
    logic [rfmb_pkg::TAP_IDX_W-1:0]    in_idx;
    rfmb_pkg::sample_t                 in_val;
    logic [rfmb_pkg::ROW_W-1:0]        n_new;
    logic [rfmb_pkg::ROW_W-1:0]        n_less;

    // effective kernel size and half width
    always_comb begin
        if (tap_count > rfmb_pkg::CNT_W'(rfmb_pkg::MAX_TAPS)) begin
            k_eff = rfmb_pkg::CNT_W'(rfmb_pkg::MAX_TAPS);
        end else begin
            k_eff = tap_count;
        end
        half = rfmb_pkg::IDX_W'(k_eff >> 1);
    end

    // handshake: taps wait for an empty back end, pixels for a free issuer
    assign is_tap    = (s_tuser == rfmb_pkg::KIND_TAP);
    assign final_job = pend_reg && (!jlast_reg || jd_reg == '0);
    assign free      = !pend_reg || (final_job && push_ready);
    assign s_tready  = is_tap ? (!pend_reg && status.queue_empty && status.back_empty) : free;
    assign accept    = s_tvalid && s_tready;
    assign in_idx    = s_tdata[rfmb_pkg::TAP_IDX_W-1:0];
    assign in_val    = rfmb_pkg::sample_t'(s_tdata[rfmb_pkg::S_DATA_BITS-1:rfmb_pkg::TAP_IDX_W]);
    assign n_new     = (rowpos_reg == '1) ? rowpos_reg : rowpos_reg + 1'b1;
    assign n_less    = n_new - 1'b1;
    assign taps      = taps_reg;
    assign push      = pend_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rowpos_reg <= '0;
            pend_reg   <= 1'b0;
            jd_reg     <= '0;
            jn_reg     <= '0;
            jshort_reg <= 1'b0;
            jlast_reg  <= 1'b0;
        end else if (accept && !is_tap) begin
            jn_reg <= n_new;
            if (!s_tlast) begin
                rowpos_reg <= n_new;
                jlast_reg  <= 1'b0;
                jshort_reg <= 1'b0;
                jd_reg     <= half;
                pend_reg   <= (n_new >= rfmb_pkg::ROW_W'(half) + 1'b1);
            end else begin
                rowpos_reg <= '0;
                jlast_reg  <= 1'b1;
                jshort_reg <= (n_new < rfmb_pkg::ROW_W'(half));
                jd_reg     <= (n_less < rfmb_pkg::ROW_W'(half)) ?
                              n_less[rfmb_pkg::IDX_W-1:0] : half;
                pend_reg   <= 1'b1;
            end
        end else if (pend_reg && push_ready) begin
            if (final_job) begin
                pend_reg <= 1'b0;
            end else begin
                jd_reg <= jd_reg - 1'b1;
            end
        end
    end

    // tap store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taps_reg <= '0;
        end else if (accept && is_tap && in_idx < rfmb_pkg::TAP_IDX_W'(rfmb_pkg::MAX_TAPS)) begin
            taps_reg[in_idx[rfmb_pkg::IDX_W-1:0]] <= in_val;
        end
    end

    // sample window, newest at position 0
    always_ff @(posedge aclk) begin
        if (accept && !is_tap) begin
            win_reg[0] <= in_val;
            for (int i = 1; i < rfmb_pkg::MAX_TAPS; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    // padded sample for each lane of the current job
    always_comb begin
        logic signed [rfmb_pkg::OFF_W-1:0] o;
        logic [rfmb_pkg::OFF_W-1:0]        m;
        logic [rfmb_pkg::OFF_W-1:0]        idx;
        logic                              ok;
        job.row_done  = jlast_reg && (jd_reg == '0);
        job.short_row = jshort_reg;
        for (int k = 0; k < rfmb_pkg::MAX_TAPS; k++) begin
            o   = rfmb_pkg::OFF_W'(jd_reg) + rfmb_pkg::OFF_W'(half) - rfmb_pkg::OFF_W'(k);
            m   = '0;
            idx = '0;
            ok  = 1'b0;
            if (rfmb_pkg::CNT_W'(k) >= k_eff) begin
                ok = 1'b0;
            end else if (o < 0) begin
                // mirror beyond the newest pixel
                m   = -o - 1'b1;
                ok  = mirror_mode && (rfmb_pkg::ROW_W'(m) < jn_reg);
                idx = m;
            end else if (jn_reg <= rfmb_pkg::ROW_W'(o)) begin
                // mirror before the first pixel of the row
                m   = o - jn_reg[rfmb_pkg::OFF_W-1:0];
                ok  = mirror_mode && (rfmb_pkg::ROW_W'(m) < jn_reg);
                idx = jn_reg[rfmb_pkg::OFF_W-1:0] - 1'b1 - m;
            end else begin
                ok  = 1'b1;
                idx = o;
            end
            job.samples[k] = ok ? win_reg[idx[rfmb_pkg::IDX_W-1:0]] : '0;
        end
    end

endmodule

[hdl/rfmb_queue.sv]
// two-entry job queue between front and back
// depends on rfmb_pkg
module rfmb_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  rfmb_pkg::job_t  wr_job,
    output logic            rd_valid,
    input  logic            rd_ready,
    output rfmb_pkg::job_t  rd_job
);

    rfmb_pkg::job_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           do_wr;
    logic           do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_job   = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

[hdl/rfmb_back.sv]
// back end: lane multipliers, registered adder tree, rounding and output register
// depends on rfmb_pkg
module rfmb_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              job_valid,
    output logic                              job_ready,
    input  rfmb_pkg::job_t                    job,
    input  rfmb_pkg::tap_vec_t                taps,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rfmb_pkg::M_TDATA_W-1:0]    m_tdata,  // filtered_pixel
    output logic [1:0]                        m_tuser,  // row_done, short_row
    output logic                              busy
);

    localparam logic signed [rfmb_pkg::ACC_W-1:0] SAT_HI =
        {{(rfmb_pkg::ACC_W-rfmb_pkg::SAMPLE_BITS+1){1'b0}}, {(rfmb_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [rfmb_pkg::ACC_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [rfmb_pkg::ACC_W-1:0] HALF_LSB =
        rfmb_pkg::ACC_W'(1) << (rfmb_pkg::FRAC_BITS - 1);

    logic signed [rfmb_pkg::PROD_W-1:0] prod_reg [rfmb_pkg::MAX_TAPS];
    logic signed [rfmb_pkg::ACC_W-1:0]  psum_reg [rfmb_pkg::GROUPS];
    logic signed [rfmb_pkg::ACC_W-1:0]  sum_reg;
    logic [1:0]                         flag1_reg, flag2_reg, flag3_reg;
    logic                               v1_reg, v2_reg, v3_reg, vout_reg;
    rfmb_pkg::sample_t                  pix_reg;
    logic [1:0]                         fout_reg;
    logic                               en;
    logic signed [rfmb_pkg::ACC_W-1:0]  psum_next [rfmb_pkg::GROUPS];
    logic signed [rfmb_pkg::ACC_W-1:0]  sum_next;
    logic signed [rfmb_pkg::ACC_W-1:0]  rnd;
    logic signed [rfmb_pkg::ACC_W-1:0]  q;
    rfmb_pkg::sample_t                  pix_next;

    // whole pipeline moves unless the output register is held
    assign en        = !vout_reg || m_tready;
    assign job_ready = en;
    assign busy      = v1_reg || v2_reg || v3_reg || vout_reg;
    assign m_tvalid  = vout_reg;
    assign m_tdata   = rfmb_pkg::M_TDATA_W'(pix_reg);
    assign m_tuser   = fout_reg;

    // group sums of eight products
    always_comb begin
        for (int g = 0; g < rfmb_pkg::GROUPS; g++) begin
            psum_next[g] = '0;
            for (int j = 0; j < 8; j++) begin
                if (g * 8 + j < rfmb_pkg::MAX_TAPS) begin
                    psum_next[g] = psum_next[g] + rfmb_pkg::ACC_W'(prod_reg[g * 8 + j]);
                end
            end
        end
        sum_next = '0;
        for (int g = 0; g < rfmb_pkg::GROUPS; g++) begin
            sum_next = sum_next + psum_reg[g];
        end
    end

    // round to nearest, ties up, then saturate
    always_comb begin
        rnd = sum_reg + HALF_LSB;
        q   = rnd >>> rfmb_pkg::FRAC_BITS;
        if (q > SAT_HI) begin
            pix_next = rfmb_pkg::sample_t'(SAT_HI);
        end else if (q < SAT_LO) begin
            pix_next = rfmb_pkg::sample_t'(SAT_LO);
        end else begin
            pix_next = rfmb_pkg::sample_t'(q);
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end else if (en) begin
            v1_reg   <= job_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            vout_reg <= v3_reg;
        end
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < rfmb_pkg::MAX_TAPS; k++) begin
                prod_reg[k] <= $signed(job.samples[k]) * $signed(taps[k]);
            end
            flag1_reg <= {job.short_row, job.row_done};
            for (int g = 0; g < rfmb_pkg::GROUPS; g++) begin
                psum_reg[g] <= psum_next[g];
            end
            flag2_reg <= flag1_reg;
            sum_reg   <= sum_next;
            flag3_reg <= flag2_reg;
            pix_reg   <= pix_next;
            fout_reg  <= flag3_reg;
        end
    end

endmodule

[hdl/row_fir_mirror_boundary.sv]
// row fir filter top level: register port, front end, job queue, back end
// depends on rfmb_pkg, rfmb_front, rfmb_queue, rfmb_back
//
// usage: the s_ channel carries two kinds of item selected by s_tuser: a tap
// write (tap_index and sample_value in tdata) or a row pixel (tlast marks the
// last pixel of a row). The m_ channel returns filtered pixels; tuser bit 0
// is row_done, bit 1 is short_row. The cfg_ channel writes tap_count (index 0)
// and mirror_mode (index 1); it is always ready, and the user must write them
// only while the block is idle, which the block does not enforce. While the
// queue takes jobs, pixels are taken and outputs issued one per cycle; a
// one-output pixel's job is offered the cycle after acceptance, and a row's
// last pixel issues up to tap_count/2+1 outputs while the channel waits. A tap
// write waits until every issued output has left the block. From issue to
// m_tvalid a job passes the queue, multiply lanes, two adder tree stages and
// rounding register. A stalled receiver holds the whole back pipeline; the
// two-entry queue then fills and the input channel stops. Reset clears taps,
// row position, queue and all valid bits, sets tap_count 1 and mirror_mode 1.
module row_fir_mirror_boundary (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rfmb_pkg::S_TDATA_W-1:0]      s_tdata,   // tap_index, sample_value
    input  logic                                s_tuser,   // kind
    input  logic                                s_tlast,   // last_in_row
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rfmb_pkg::M_TDATA_W-1:0]      m_tdata,   // filtered_pixel
    output logic [1:0]                          m_tuser,   // row_done, short_row
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rfmb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [rfmb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [rfmb_pkg::CNT_W-1:0] tap_count_reg;
    logic                       mirror_mode_reg;
    rfmb_pkg::status_t          status;
    rfmb_pkg::job_t             front_job;
    rfmb_pkg::job_t             back_job;
    rfmb_pkg::tap_vec_t         taps;
    logic                       push;
    logic                       push_ready;
    logic                       job_valid;
    logic                       job_ready;
    logic                       back_busy;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg   <= rfmb_pkg::CNT_W'(1);
            mirror_mode_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                rfmb_pkg::CFG_TAP_COUNT:   tap_count_reg   <= cfg_data[rfmb_pkg::CNT_W-1:0];
                rfmb_pkg::CFG_MIRROR_MODE: mirror_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign status.queue_empty = !job_valid;
    assign status.back_empty  = !back_busy;

    rfmb_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .tap_count   (tap_count_reg),
        .mirror_mode (mirror_mode_reg),
        .status      (status),
        .push        (push),
        .push_ready  (push_ready),
        .job         (front_job),
        .taps        (taps)
    );

    rfmb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push),
        .wr_ready (push_ready),
        .wr_job   (front_job),
        .rd_valid (job_valid),
        .rd_ready (job_ready),
        .rd_job   (back_job)
    );

    rfmb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (back_job),
        .taps      (taps),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .busy      (back_busy)
    );

endmodule

[hdl/rfmb_checker.sv]
// port-level checks for the row fir filter, bound to the top level
// depends on rfmb_pkg and row_fir_mirror_boundary_defines.svh
`include "row_fir_mirror_boundary_defines.svh"

module rfmb_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [rfmb_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [1:0]                        m_tuser
);

    // a stalled result holds
    `RFMB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // no result leaves right after reset
    `RFMB_ASSERT_RST(a_reset_quiet, !aresetn, !m_tvalid, "result valid after reset")

    // a tap write is only taken when no result is waiting
    `RFMB_ASSERT_IMP(a_tap_idle, s_tvalid && s_tready && s_tuser == rfmb_pkg::KIND_TAP, !m_tvalid, "tap taken while busy")

endmodule

bind row_fir_mirror_boundary rfmb_checker u_rfmb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[verif/row_fir_mirror_boundary_test.sv]
// testbench for the row fir filter with mirror or zero boundary padding
// depends on rfmb_pkg and row_fir_mirror_boundary; checks every output item
// against a predictor of the filter, under random idling on both sides
`timescale 1ns / 1ps

// one expected output item
typedef struct {
    logic signed [15:0] pixel;
    logic               row_done;
    logic               short_row;
} fir_result_t;

class row_fir_scoreboard;
    longint       taps [rfmb_pkg::MAX_TAPS];
    longint       window [rfmb_pkg::MAX_TAPS];
    int unsigned  row_pos;
    int unsigned  tap_count;
    bit           mirror;
    fir_result_t  pending [$];
    int           fails;

    function new();
        foreach (taps[i]) begin
            taps[i] = 0;
            window[i] = 0;
        end
        row_pos = 0;
        tap_count = 1;
        mirror = 1;
        fails = 0;
    endfunction

    function void write_reg(logic [rfmb_pkg::CFG_ADDR_W-1:0] addr,
                            logic [rfmb_pkg::CFG_DATA_W-1:0] data);
        if (addr == rfmb_pkg::CFG_TAP_COUNT)
            tap_count = 32'(data);
        else if (addr == rfmb_pkg::CFG_MIRROR_MODE)
            mirror = data[0];
    endfunction

    // padded sample at offset o from the newest pixel, n pixels in the row
    function longint padded_sample(int o, int n);
        int m;
        if (o < 0) begin
            m = -o - 1;
            if (!mirror || m >= n || m >= rfmb_pkg::MAX_TAPS) return 0;
            return window[m];
        end
        if (o + 1 > n) begin
            m = o - n;
            if (!mirror || m >= n) return 0;
            m = n - 1 - m;
            return (m < rfmb_pkg::MAX_TAPS) ? window[m] : 0;
        end
        return (o < rfmb_pkg::MAX_TAPS) ? window[o] : 0;
    endfunction

    function logic signed [15:0] filtered_at(int d, int h, int k_used, int n);
        longint acc;
        longint r;
        acc = 0;
        for (int k = 0; k < k_used; k++)
            acc += padded_sample(d + h - k, n) * taps[k];
        // round half up, then saturate
        r = (acc + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function void note_item(logic kind, logic [4:0] idx, logic signed [15:0] value,
                            logic last);
        int k_used;
        int h;
        int n;
        int dmax;
        fir_result_t res;
        k_used = (tap_count > rfmb_pkg::MAX_TAPS) ? rfmb_pkg::MAX_TAPS : tap_count;
        h = k_used / 2;
        if (kind == rfmb_pkg::KIND_TAP) begin
            if (idx < rfmb_pkg::MAX_TAPS) taps[idx] = value;
            return;
        end
        for (int i = rfmb_pkg::MAX_TAPS - 1; i > 0; i--)
            window[i] = window[i-1];
        window[0] = value;
        if (row_pos < 65535) row_pos++;
        n = row_pos;
        if (!last) begin
            if (n >= h + 1) begin
                res.pixel = filtered_at(h, h, k_used, n);
                res.row_done = 0;
                res.short_row = 0;
                pending.push_back(res);
            end
            return;
        end
        // row end flushes the remaining outputs
        dmax = (n - 1 < h) ? n - 1 : h;
        for (int d = dmax; d >= 0; d--) begin
            res.pixel = filtered_at(d, h, k_used, n);
            res.row_done = (d == 0);
            res.short_row = (n < h);
            pending.push_back(res);
        end
        row_pos = 0;
    endfunction

    function void check_result(logic [rfmb_pkg::M_TDATA_W-1:0] data, logic [1:0] user);
        fir_result_t exp_res;
        if (pending.size() == 0) begin
            $display("%0t: unexpected output item pixel %0d flags %b", $time,
                     $signed(data[15:0]), user);
            fails++;
            return;
        end
        exp_res = pending.pop_front();
        if (data[15:0] !== exp_res.pixel) begin
            $display("%0t: filtered_pixel expected %0d actual %0d", $time,
                     exp_res.pixel, $signed(data[15:0]));
            fails++;
        end
        if (user[0] !== exp_res.row_done) begin
            $display("%0t: row_done expected %b actual %b", $time,
                     exp_res.row_done, user[0]);
            fails++;
        end
        if (user[1] !== exp_res.short_row) begin
            $display("%0t: short_row expected %b actual %b", $time,
                     exp_res.short_row, user[1]);
            fails++;
        end
    endfunction
endclass

module row_fir_mirror_boundary_test;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 12;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [rfmb_pkg::S_TDATA_W-1:0]   s_tdata;
    logic                             s_tuser;
    logic                             s_tlast;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [rfmb_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [1:0]                       m_tuser;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [rfmb_pkg::CFG_ADDR_W-1:0]  cfg_addr;
    logic [rfmb_pkg::CFG_DATA_W-1:0]  cfg_data;

    row_fir_scoreboard filter_sb;
    bit                no_idle;
    int                items_sent;
    int                cycles;

    row_fir_mirror_boundary DUT (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("row_fir_mirror_boundary test failed");
            $finish;
        end
    end

    function int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    // send one input item
    task send_item(logic kind, logic [4:0] idx, logic signed [15:0] value, logic last);
        int gap;
        gap = draw_gap();
        repeat (gap) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tuser = kind;
        s_tdata = {3'b0, value, idx};
        s_tlast = last;
        s_tvalid = 1;
        do @(posedge aclk); while (!s_tready);
        filter_sb.note_item(kind, idx, value, last);
        items_sent++;
        @(negedge aclk);
    endtask

    task send_pixel(logic signed [15:0] value, logic last);
        send_item(rfmb_pkg::KIND_PIXEL, 5'($urandom_range(0, 31)), value, last);
    endtask

    task send_tap(logic [4:0] idx, logic signed [15:0] value);
        send_item(rfmb_pkg::KIND_TAP, idx, value, 1'($urandom_range(0, 1)));
    endtask

    task write_reg(logic [rfmb_pkg::CFG_ADDR_W-1:0] addr,
                   logic [rfmb_pkg::CFG_DATA_W-1:0] data);
        s_tvalid = 0;
        cfg_addr = addr;
        cfg_data = data;
        cfg_valid = 1;
        do @(posedge aclk); while (!cfg_ready);
        filter_sb.write_reg(addr, data);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    // hold the sender until every expected item is out, then let the pipe settle
    task wait_idle();
        s_tvalid = 0;
        while (filter_sb.pending.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function logic signed [15:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    task send_row(int len);
        for (int i = 0; i < len; i++)
            send_pixel(random_sample(), i == len - 1);
    endtask

    // receiver with random stalls
    initial begin
        m_tready = 0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            repeat (draw_gap()) begin
                m_tready = 0;
                @(negedge aclk);
            end
            m_tready = 1;
            do @(posedge aclk); while (!m_tvalid);
            filter_sb.check_result(m_tdata, m_tuser);
            @(negedge aclk);
        end
    end

    initial begin
        int len;
        filter_sb = new();
        no_idle = 0;
        items_sent = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = rfmb_pkg::KIND_TAP;
        s_tlast = 0;
        cfg_valid = 0;
        cfg_addr = rfmb_pkg::CFG_TAP_COUNT;
        cfg_data = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // directed: reset taps give zero output, ignored tap index, full-scale taps and samples
        send_row(2);
        send_tap(5'd31, 16'sh7fff);
        send_tap(5'd0, 16'sh7fff);
        send_pixel(16'sh7fff, 0);
        send_pixel(16'sh8000, 1);
        wait_idle();
        write_reg(rfmb_pkg::CFG_TAP_COUNT, 5'd5);
        send_tap(5'd1, 16'sh8000);
        send_tap(5'd2, 16'sh4000);
        send_tap(5'd3, 16'sh2000);
        send_tap(5'd4, 16'sh7fff);
        // single pixel row is short, two pixels exactly h, then a longer row
        send_row(1);
        send_row(2);
        send_row(4);
        wait_idle();
        // zero padding and the widest kernel on a short row
        write_reg(rfmb_pkg::CFG_MIRROR_MODE, 5'd0);
        write_reg(rfmb_pkg::CFG_TAP_COUNT, 5'd31);
        send_row(3);
        wait_idle();
        // zero taps, then an even count
        write_reg(rfmb_pkg::CFG_TAP_COUNT, 5'd0);
        send_row(3);
        wait_idle();
        write_reg(rfmb_pkg::CFG_TAP_COUNT, 5'd4);
        write_reg(rfmb_pkg::CFG_MIRROR_MODE, 5'd1);
        send_row(5);

        // random phases: new settings, a few taps, then whole rows
        while (items_sent < 310) begin
            wait_idle();
            no_idle = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 5))
                0: write_reg(rfmb_pkg::CFG_TAP_COUNT, 5'd31);
                1: write_reg(rfmb_pkg::CFG_TAP_COUNT, 5'd1);
                default: write_reg(rfmb_pkg::CFG_TAP_COUNT, 5'($urandom_range(0, 31)));
            endcase
            write_reg(rfmb_pkg::CFG_MIRROR_MODE, 5'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 6))
                send_tap(5'($urandom_range(0, 31)), 16'($urandom));
            repeat ($urandom_range(1, 4)) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
                send_row(len);
            end
        end

        wait_idle();
        if (filter_sb.fails == 0)
            $display("row_fir_mirror_boundary test passed");
        else
            $display("row_fir_mirror_boundary test failed");
        $finish;
    end
endmodule
